@@ src/fla_pkg.sv @@
// Shared types and constants for the free-list slot allocator.
// No dependencies; every other file refers to it by scoped names.
package fla_pkg;

	// Fixed field widths of the ports
	localparam int IDX_W  = 10;
	localparam int ADDR_W = 64;
	localparam int STR_W  = 16;

	// Reset value of the slot stride register
	localparam logic [STR_W-1:0] STRIDE_RST = 16'd32;

	typedef enum logic [1:0] {
		CMD_ALLOC      = 2'd0,
		CMD_REL_INDEX  = 2'd1,
		CMD_REL_HANDLE = 2'd2,
		CMD_TRANSLATE  = 2'd3
	} fla_cmd_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_RANGE = 3'd2,
		ST_NULL  = 3'd3,
		ST_FULL  = 3'd4
	} fla_status_t;

	typedef enum logic [1:0] {
		REG_CPU_BASE = 2'd0,
		REG_GPU_BASE = 2'd1,
		REG_STRIDE   = 2'd2
	} fla_reg_t;

	// Top-level sequencer
	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_POP,
		S_DIV,
		S_PUSH,
		S_MUL,
		S_ADD,
		S_RESULT
	} fla_state_t;

	// Divider sequencer
	typedef enum logic [2:0] {
		DV_IDLE,
		DV_SUB,
		DV_CMP,
		DV_STEP,
		DV_DONE
	} fla_div_state_t;

	typedef struct packed {
		logic pop;
		logic push;
	} stk_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stk_st_t;

	typedef struct packed {
		logic mul_en;
		logic add_en;
	} hnd_ctl_t;

endpackage

@@ src/fla_stack.sv @@
// Free-index stack: memory of slot indices plus fill count and low-water mark.
// Depends on fla_pkg for the command and status structs.
module fla_stack #(
	parameter int SLOTS = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fla_pkg::stk_cmd_t         cmd,
	input  logic [$clog2(SLOTS)-1:0]  push_data,
	output fla_pkg::stk_st_t          st,
	output logic [$clog2(SLOTS)-1:0]  rd_data
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	logic [SW-1:0] mem_q [SLOTS];
	logic [CW-1:0] count_q;
	logic [CW-1:0] low_q;
	logic [SW-1:0] rd_q;
	logic [SW-1:0] addr_q;
	logic          fresh_q;

	logic [CW-1:0] count_m1;
	logic [SW-1:0] pop_addr;
	logic [SW-1:0] push_addr;
	logic          pop_fresh;

	// Positions below the lowest depth ever reached were never written and read as their own index
	assign count_m1  = count_q - CW'(1);
	assign pop_addr  = count_m1[SW-1:0];
	assign push_addr = count_q[SW-1:0];
	assign pop_fresh = count_m1 < low_q;

	// Write on push, registered read on pop
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[push_addr] <= push_data;
		end
		if (cmd.pop) begin
			rd_q   <= mem_q[pop_addr];
			addr_q <= pop_addr;
		end
	end

	// Advance fill count and low-water mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(SLOTS);
			low_q   <= CW'(SLOTS);
			fresh_q <= 1'b0;
		end else begin
			if (cmd.pop) begin
				count_q <= count_m1;
				fresh_q <= pop_fresh;
				if (pop_fresh) begin
					low_q <= count_m1;
				end
			end else if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	assign rd_data  = fresh_q ? addr_q : rd_q;
	assign st.empty = (count_q == '0);
	assign st.full  = (count_q == CW'(SLOTS));

endmodule

@@ src/fla_div.sv @@
// Handle-to-index divider: one restoring compare-and-subtract step per cycle.
// Depends on fla_pkg for its state type.
module fla_div #(
	parameter int SLOTS = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [63:0]               address,
	input  logic [63:0]               base,
	input  logic [15:0]               stride,
	output logic                      done,
	output logic                      ovf,
	output logic [$clog2(SLOTS)-1:0]  quo
);

	localparam int IW  = $clog2(SLOTS);
	localparam int CNW = $clog2(IW + 1);

	fla_pkg::fla_div_state_t state_q, state_d;

	logic [63:0]    diff_q;
	logic [15:0]    rem_q;
	logic [IW-1:0]  dq_q;
	logic [CNW-1:0] cnt_q;
	logic           ovf_q;

	logic [16:0]    trial;
	logic [16:0]    trial_sub;
	logic           trial_ge;
	logic           hi_ge;

	// Shared step unit: shift in the next dividend bit, compare and subtract
	assign trial     = {rem_q, dq_q[IW-1]};
	assign trial_ge  = trial >= {1'b0, stride};
	assign trial_sub = trial - {1'b0, stride};

	// Quotient reaches 2^IW or beyond; a zero stride always lands here
	assign hi_ge = diff_q[63:IW] >= (64 - IW)'(stride);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fla_pkg::DV_IDLE: begin
				if (start) begin
					state_d = fla_pkg::DV_SUB;
				end
			end
			fla_pkg::DV_SUB: begin
				state_d = fla_pkg::DV_CMP;
			end
			fla_pkg::DV_CMP: begin
				state_d = hi_ge ? fla_pkg::DV_DONE : fla_pkg::DV_STEP;
			end
			fla_pkg::DV_STEP: begin
				if (cnt_q == CNW'(1)) begin
					state_d = fla_pkg::DV_DONE;
				end
			end
			fla_pkg::DV_DONE: begin
				state_d = fla_pkg::DV_IDLE;
			end
			default: begin
				state_d = fla_pkg::DV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fla_pkg::DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			fla_pkg::DV_SUB: begin
				diff_q <= address - base;
			end
			fla_pkg::DV_CMP: begin
				ovf_q <= hi_ge;
				rem_q <= diff_q[IW+15:IW];
				dq_q  <= diff_q[IW-1:0];
				cnt_q <= CNW'(IW);
			end
			fla_pkg::DV_STEP: begin
				rem_q <= trial_ge ? trial_sub[15:0] : trial[15:0];
				dq_q  <= IW'({dq_q, trial_ge});
				cnt_q <= cnt_q - CNW'(1);
			end
			default: begin
			end
		endcase
	end

	// Outputs
	always_comb begin
		done = (state_q == fla_pkg::DV_DONE);
		ovf  = ovf_q;
		quo  = dq_q;
	end

endmodule

@@ src/fla_handle.sv @@
// Handle generator: index times stride, registered, then added to both bases.
// Depends on fla_pkg for the control struct.
module fla_handle #(
	parameter int SLOTS = 1024
) (
	input  logic                      clk,
	input  fla_pkg::hnd_ctl_t         ctl,
	input  logic [$clog2(SLOTS)-1:0]  idx,
	input  logic [15:0]               stride,
	input  logic [63:0]               cpu_base,
	input  logic [63:0]               gpu_base,
	output logic [63:0]               cpu_hnd,
	output logic [63:0]               gpu_hnd
);

	localparam int SW = $clog2(SLOTS);
	localparam int PW = SW + 16;

	logic [PW-1:0] prod_s1;
	logic [63:0]   cpu_s2;
	logic [63:0]   gpu_s2;

	// Multiply, then offset both bases
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= PW'(idx) * PW'(stride);
		end
		if (ctl.add_en) begin
			cpu_s2 <= cpu_base + 64'(prod_s1);
			gpu_s2 <= gpu_base + 64'(prod_s1);
		end
	end

	assign cpu_hnd = cpu_s2;
	assign gpu_hnd = gpu_s2;

endmodule

@@ src/free_list_slot_allocator.sv @@
// Free-list slot allocator top level: sequencer, configuration and result register.
// Depends on fla_pkg, fla_stack, fla_div and fla_handle.
//
// Hands out descriptor slot indices from a last-in-first-out free stack and maps
// indices to CPU and GPU handles (base + index * stride). One command is worked on
// at a time and in_ready is low while it runs. Allocate pops the stack and then
// forms the handles, translate forms the handles of the given index, release by
// index pushes it, and release by handle runs the divider first, which resolves
// one quotient bit per cycle; empty, null and out-of-range cases finish sooner.
// A result waiting in the output register does not stop the next command from
// being accepted. The stack needs no clearing pass after reset: untouched entries
// read as their own index. Configuration writes are always ready.
module free_list_slot_allocator #(
	parameter int SLOTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [9:0]  slot_index,
	input  logic [63:0] cpu_address,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  result_index,
	output logic [63:0] cpu_handle,
	output logic [63:0] gpu_handle,
	output logic [2:0]  status
);

	localparam int SW = $clog2(SLOTS);

	fla_pkg::fla_state_t  state_q, state_d;

	// Configuration
	logic [63:0] cpu_base_q;
	logic [63:0] gpu_base_q;
	logic [15:0] stride_q;

	// Captured command word
	fla_pkg::fla_cmd_t cmd_q;
	logic [9:0]        sidx_q;
	logic [63:0]       addr_q;

	// Working registers
	logic [SW-1:0]        idx_q;
	logic [9:0]           rix_q;
	fla_pkg::fla_status_t st_q;

	// Output register
	logic        out_valid_q;
	logic [9:0]  out_rix_q;
	logic [63:0] out_cpu_q;
	logic [63:0] out_gpu_q;
	logic [2:0]  out_st_q;

	// Sub-unit connections
	fla_pkg::stk_cmd_t stk_cmd;
	fla_pkg::stk_st_t  stk_st;
	fla_pkg::hnd_ctl_t hnd_ctl;
	logic [SW-1:0]     stk_rd;
	logic              div_start;
	logic              div_done;
	logic              div_ovf;
	logic [SW-1:0]     div_quo;
	logic [63:0]       cpu_hnd;
	logic [63:0]       gpu_hnd;

	// Decisions of the output block
	logic                 st_ld;
	fla_pkg::fla_status_t st_d;
	logic                 rix_ld;
	logic [9:0]           rix_d;
	logic                 idx_ld;
	logic [SW-1:0]        idx_d;
	logic                 out_load;

	// Index widths bridged through a 17-bit form
	logic [16:0] sidx_w;
	logic [16:0] stk_w;
	logic [16:0] quo_w;
	logic        sidx_bad;
	logic        quo_bad;
	logic        hnd_keep;

	assign sidx_w   = 17'(sidx_q);
	assign stk_w    = 17'(stk_rd);
	assign quo_w    = 17'(div_quo);
	assign sidx_bad = sidx_w >= 17'(SLOTS);
	assign quo_bad  = div_ovf || (quo_w >= 17'(SLOTS));
	assign hnd_keep = (st_q == fla_pkg::ST_OK) &&
		((cmd_q == fla_pkg::CMD_ALLOC) || (cmd_q == fla_pkg::CMD_TRANSLATE));

	fla_stack #(.SLOTS(SLOTS)) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (stk_cmd),
		.push_data (idx_q),
		.st        (stk_st),
		.rd_data   (stk_rd)
	);

	fla_div #(.SLOTS(SLOTS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.address (addr_q),
		.base    (cpu_base_q),
		.stride  (stride_q),
		.done    (div_done),
		.ovf     (div_ovf),
		.quo     (div_quo)
	);

	fla_handle #(.SLOTS(SLOTS)) u_handle (
		.clk      (clk),
		.ctl      (hnd_ctl),
		.idx      (idx_q),
		.stride   (stride_q),
		.cpu_base (cpu_base_q),
		.gpu_base (gpu_base_q),
		.cpu_hnd  (cpu_hnd),
		.gpu_hnd  (gpu_hnd)
	);

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_base_q <= '0;
			gpu_base_q <= '0;
			stride_q   <= fla_pkg::STRIDE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (fla_pkg::fla_reg_t'(cfg_index))
				fla_pkg::REG_CPU_BASE: cpu_base_q <= cfg_data;
				fla_pkg::REG_GPU_BASE: gpu_base_q <= cfg_data;
				fla_pkg::REG_STRIDE:   stride_q   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fla_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = fla_pkg::S_DISPATCH;
				end
			end
			fla_pkg::S_DISPATCH: begin
				case (cmd_q)
					fla_pkg::CMD_ALLOC:
						state_d = stk_st.empty ? fla_pkg::S_RESULT : fla_pkg::S_POP;
					fla_pkg::CMD_REL_INDEX:
						state_d = sidx_bad ? fla_pkg::S_RESULT : fla_pkg::S_PUSH;
					fla_pkg::CMD_REL_HANDLE:
						state_d = (addr_q == '0) ? fla_pkg::S_RESULT : fla_pkg::S_DIV;
					fla_pkg::CMD_TRANSLATE:
						state_d = sidx_bad ? fla_pkg::S_RESULT : fla_pkg::S_MUL;
					default:
						state_d = fla_pkg::S_RESULT;
				endcase
			end
			fla_pkg::S_POP: begin
				state_d = fla_pkg::S_MUL;
			end
			fla_pkg::S_DIV: begin
				if (div_done) begin
					state_d = quo_bad ? fla_pkg::S_RESULT : fla_pkg::S_PUSH;
				end
			end
			fla_pkg::S_PUSH: begin
				state_d = fla_pkg::S_RESULT;
			end
			fla_pkg::S_MUL: begin
				state_d = fla_pkg::S_ADD;
			end
			fla_pkg::S_ADD: begin
				state_d = fla_pkg::S_RESULT;
			end
			fla_pkg::S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					state_d = fla_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fla_pkg::S_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		stk_cmd   = '0;
		hnd_ctl   = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		st_ld     = 1'b0;
		st_d      = fla_pkg::ST_OK;
		rix_ld    = 1'b0;
		rix_d     = '0;
		idx_ld    = 1'b0;
		idx_d     = sidx_w[SW-1:0];
		case (state_q)
			fla_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			fla_pkg::S_DISPATCH: begin
				st_ld  = 1'b1;
				rix_ld = 1'b1;
				case (cmd_q)
					fla_pkg::CMD_ALLOC: begin
						if (stk_st.empty) begin
							st_d = fla_pkg::ST_EMPTY;
						end else begin
							stk_cmd.pop = 1'b1;
						end
					end
					fla_pkg::CMD_REL_HANDLE: begin
						if (addr_q == '0) begin
							st_d = fla_pkg::ST_NULL;
						end else begin
							div_start = 1'b1;
						end
					end
					default: begin
						// release by index and translate echo the index
						rix_d = sidx_q;
						if (sidx_bad) begin
							st_d = fla_pkg::ST_RANGE;
						end else begin
							idx_ld = 1'b1;
						end
					end
				endcase
			end
			fla_pkg::S_POP: begin
				idx_ld = 1'b1;
				idx_d  = stk_rd;
				rix_ld = 1'b1;
				rix_d  = stk_w[9:0];
			end
			fla_pkg::S_DIV: begin
				if (div_done) begin
					if (quo_bad) begin
						st_ld = 1'b1;
						st_d  = fla_pkg::ST_RANGE;
					end else begin
						idx_ld = 1'b1;
						idx_d  = div_quo;
						rix_ld = 1'b1;
						rix_d  = quo_w[9:0];
					end
				end
			end
			fla_pkg::S_PUSH: begin
				if (stk_st.full) begin
					st_ld = 1'b1;
					st_d  = fla_pkg::ST_FULL;
				end else begin
					stk_cmd.push = 1'b1;
				end
			end
			fla_pkg::S_MUL: begin
				hnd_ctl.mul_en = 1'b1;
			end
			fla_pkg::S_ADD: begin
				hnd_ctl.add_en = 1'b1;
			end
			fla_pkg::S_RESULT: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fla_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the command word and hold working values
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= fla_pkg::fla_cmd_t'(command);
			sidx_q <= slot_index;
			addr_q <= cpu_address;
		end
		if (st_ld) begin
			st_q <= st_d;
		end
		if (rix_ld) begin
			rix_q <= rix_d;
		end
		if (idx_ld) begin
			idx_q <= idx_d;
		end
	end

	// Output register: drop the word when taken, load the next result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rix_q <= rix_q;
			out_cpu_q <= hnd_keep ? cpu_hnd : '0;
			out_gpu_q <= hnd_keep ? gpu_hnd : '0;
			out_st_q  <= st_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_index = out_rix_q;
	assign cpu_handle   = out_cpu_q;
	assign gpu_handle   = out_gpu_q;
	assign status       = out_st_q;

	// Checks
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cmd.pop |-> !stk_st.empty)
		else $error("pop issued on an empty free stack");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cmd.push |-> !stk_st.full)
		else $error("push issued on a full free stack");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == fla_pkg::S_DIV))
		else $error("divider finished outside the divide state");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fla_pkg::S_RESULT) && out_valid_q && !out_ready
		|=> (state_q == fla_pkg::S_RESULT))
		else $error("result left the sequencer while the output word was still held");

endmodule
